### rtl/url_path_decode_normalize_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef URL_PATH_DECODE_NORMALIZE_MACROS_SVH
`define URL_PATH_DECODE_NORMALIZE_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define UPN_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, also checked across reset.
`define UPN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/upn_pkg.sv
package upn_pkg;

   // Field widths and limits.
   localparam int BYTE_W         = 8;
   localparam int ROOT_W         = 12;
   localparam int MAX_RES        = 5;
   localparam int RES_CNT_W      = 3;
   localparam int PATH_LIMIT_DEF = 4096;
   localparam int RSP_DATA_W     = 16;

   // Characters with a meaning in a request path.
   localparam logic [BYTE_W-1:0] CH_QUERY    = 8'h3F;
   localparam logic [BYTE_W-1:0] CH_FRAGMENT = 8'h23;
   localparam logic [BYTE_W-1:0] CH_PERCENT  = 8'h25;
   localparam logic [BYTE_W-1:0] CH_DOT      = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_SLASH    = 8'h2F;

   // Escape decoder phase.
   typedef enum logic [1:0] {
      ESC_IDLE = 2'd0,
      ESC_HIGH = 2'd1,
      ESC_LOW  = 2'd2
   } esc_type;

   // Fault kinds; the same codes serve as the final status.
   typedef enum logic [1:0] {
      FAULT_NONE    = 2'd0,
      FAULT_INVALID = 2'd1,
      FAULT_LONG    = 2'd2
   } fault_type;

   // Progress through the current segment.
   typedef enum logic [1:0] {
      SEG_NONE = 2'd0,
      SEG_ONE  = 2'd1,
      SEG_TWO  = 2'd2,
      SEG_BODY = 2'd3
   } seg_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  val;
   } hex_type;

   // One result beat.
   typedef struct packed {
      fault_type           status;
      logic                eop;
      logic                vld;
      logic [BYTE_W-1:0]   data;
   } entry_type;

   // All result beats of one input beat, handed to the result buffer.
   typedef struct packed {
      logic                        load;
      logic [RES_CNT_W-1:0]        cnt;
      entry_type [MAX_RES-1:0]     ent;
   } bundle_type;

   // Value of one hex digit, with a flag for a non-digit.
   function automatic hex_type hex_value(input logic [BYTE_W-1:0] b);
      hex_type r;
      r.ok  = 1'b1;
      r.val = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r.val = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r.val = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r.val = 4'(b - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

### rtl/url_path_decode_normalize.sv
// Channel  Direction  Beat carries
// req_     in         tdata: path_byte [7:0]; tlast: last_byte
// rsp_     out        tdata: out_byte [7:0], status [9:8]; tuser: byte_valid;
//                     tlast: end_of_path
// csr_     in         wr_data: root_length [11:0], taken when wr_en is high
//
// An input beat is taken every cycle while each causes at most one result beat and rsp_ is not stalled.
// A beat causing more than one result beat holds the next one back until the single
// output port draining the five-entry result buffer is sending its last waiting beat.
// An input beat passes through the input register, then the result buffer, before leaving on rsp_.
// Reset is synchronous and clears the request state and root_length.
// A stall on rsp_ backs up into req_tready once the input register holds a beat the result buffer cannot take.
module url_path_decode_normalize #(
   parameter int PATH_LIMIT = upn_pkg::PATH_LIMIT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [upn_pkg::BYTE_W-1:0]          req_tdata,   // path_byte
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [upn_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // out_byte, status
   output logic                                rsp_tuser,   // byte_valid
   output logic                                rsp_tlast,
   input  logic                                csr_wr_en,
   input  logic [upn_pkg::ROOT_W-1:0]          csr_wr_data
);

   upn_pkg::bundle_type bundle;
   logic                buf_free;

   // Input register, decoder and path normalizer.
   upn_core #(
      .PATH_LIMIT (PATH_LIMIT)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .buf_free    (buf_free),
      .bundle      (bundle)
   );

   // Result buffer feeding the output channel.
   upn_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .bundle     (bundle),
      .buf_free   (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/upn_core.sv
module upn_core #(
   parameter int PATH_LIMIT = upn_pkg::PATH_LIMIT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [upn_pkg::BYTE_W-1:0]    req_tdata,
   input  logic                          req_tlast,
   input  logic                          csr_wr_en,
   input  logic [upn_pkg::ROOT_W-1:0]    csr_wr_data,
   input  logic                          buf_free,
   output upn_pkg::bundle_type           bundle
);

   localparam int CntW = $clog2(PATH_LIMIT);
   localparam logic [CntW-1:0] LastCnt = CntW'(PATH_LIMIT - 1);
   localparam logic [upn_pkg::ROOT_W:0] LimitWide = (upn_pkg::ROOT_W + 1)'(PATH_LIMIT);

   // Input register.
   logic                          in_vld_ff, in_vld_in;
   logic [upn_pkg::BYTE_W-1:0]    in_byte_ff;
   logic                          in_last_ff;

   // Request state.
   logic [upn_pkg::ROOT_W-1:0]    root_ff;
   upn_pkg::esc_type              esc_ff, esc_in;
   logic [3:0]                    hi_ff, hi_in;
   logic                          qry_ff, qry_in;
   logic [CntW-1:0]               dcnt_ff, dcnt_in;
   logic [CntW-1:0]               ocnt_ff, ocnt_in;
   upn_pkg::seg_type              seg_ff, seg_in;
   upn_pkg::fault_type            dflt_ff, dflt_in;
   upn_pkg::fault_type            jflt_ff, jflt_in;
   logic                          pslash_ff, pslash_in;

   logic                          proc;
   upn_pkg::hex_type              hex;
   logic                          dec_vld;
   logic [upn_pkg::BYTE_W-1:0]    chr;
   logic                          first;
   logic                          join_ok;
   logic [CntW-1:0]               base;
   logic [CntW-1:0]               room;
   logic [upn_pkg::RES_CNT_W-1:0] app_k;
   logic [upn_pkg::RES_CNT_W-1:0] emit;
   logic [upn_pkg::RES_CNT_W-1:0] nb;
   logic [upn_pkg::BYTE_W-1:0]    lst [upn_pkg::MAX_RES];
   upn_pkg::fault_type            dfin, jfin, st;

   // The held beat is worked off once the result buffer can take its results.
   assign proc       = in_vld_ff && buf_free;
   assign req_tready = !in_vld_ff || proc;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (proc) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Document root length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else if (csr_wr_en) begin
         root_ff <= csr_wr_data;
      end
   end

   assign hex = upn_pkg::hex_value(in_byte_ff);

   // Decode, join and finish for the beat in the input register.
   always_comb begin
      esc_in    = esc_ff;
      hi_in     = hi_ff;
      qry_in    = qry_ff;
      dcnt_in   = dcnt_ff;
      ocnt_in   = ocnt_ff;
      seg_in    = seg_ff;
      dflt_in   = dflt_ff;
      jflt_in   = jflt_ff;
      pslash_in = pslash_ff;
      dec_vld   = 1'b0;
      chr       = in_byte_ff;
      first     = 1'b0;
      join_ok   = 1'b0;
      base      = ocnt_ff;
      room      = '0;
      app_k     = '0;
      emit      = '0;
      dfin      = upn_pkg::FAULT_NONE;
      jfin      = upn_pkg::FAULT_NONE;
      st        = upn_pkg::FAULT_NONE;
      for (int i = 0; i < upn_pkg::MAX_RES; i++) begin
         lst[i] = '0;
      end

      // Percent-escape decoding and the query cut-off.
      if (dflt_ff == upn_pkg::FAULT_NONE && !qry_ff) begin
         case (esc_ff)
            upn_pkg::ESC_IDLE: begin
               if (in_byte_ff == upn_pkg::CH_QUERY || in_byte_ff == upn_pkg::CH_FRAGMENT) begin
                  qry_in = 1'b1;
               end else if (in_byte_ff == upn_pkg::CH_PERCENT) begin
                  esc_in = upn_pkg::ESC_HIGH;
               end else begin
                  dec_vld = 1'b1;
               end
            end
            upn_pkg::ESC_HIGH: begin
               if (!hex.ok) begin
                  dflt_in = upn_pkg::FAULT_INVALID;
                  esc_in  = upn_pkg::ESC_IDLE;
               end else begin
                  hi_in  = hex.val;
                  esc_in = upn_pkg::ESC_LOW;
               end
            end
            upn_pkg::ESC_LOW: begin
               esc_in = upn_pkg::ESC_IDLE;
               chr    = {hi_ff, hex.val};
               if (!hex.ok || chr == '0) begin
                  dflt_in = upn_pkg::FAULT_INVALID;
               end else begin
                  dec_vld = 1'b1;
               end
            end
            default: begin
               esc_in = upn_pkg::ESC_IDLE;
            end
         endcase
      end

      // Decoded byte: length check, then segment handling.
      if (dec_vld) begin
         if (dcnt_ff >= LastCnt) begin
            dflt_in = upn_pkg::FAULT_LONG;
         end else begin
            first     = (dcnt_ff == '0);
            dcnt_in   = dcnt_ff + 1'b1;
            pslash_in = (chr == upn_pkg::CH_SLASH);
            if (jflt_ff == upn_pkg::FAULT_NONE) begin
               join_ok = 1'b1;
               if (first) begin
                  if (chr != upn_pkg::CH_SLASH) begin
                     jflt_in = upn_pkg::FAULT_INVALID;
                     join_ok = 1'b0;
                  end else if ({1'b0, root_ff} >= LimitWide) begin
                     jflt_in = upn_pkg::FAULT_LONG;
                     join_ok = 1'b0;
                  end else begin
                     base = root_ff[CntW-1:0];
                  end
               end
            end
         end
      end

      if (join_ok) begin
         if (chr == upn_pkg::CH_SLASH) begin
            // A segment of two dots is refused.
            if (seg_ff == upn_pkg::SEG_TWO) begin
               jflt_in = upn_pkg::FAULT_INVALID;
            end
            seg_in = upn_pkg::SEG_NONE;
         end else begin
            case (seg_ff)
               upn_pkg::SEG_NONE: begin
                  if (chr == upn_pkg::CH_DOT) begin
                     seg_in = upn_pkg::SEG_ONE;
                  end else begin
                     lst[0] = upn_pkg::CH_SLASH;
                     lst[1] = chr;
                     app_k  = 3'd2;
                     seg_in = upn_pkg::SEG_BODY;
                  end
               end
               upn_pkg::SEG_ONE: begin
                  if (chr == upn_pkg::CH_DOT) begin
                     seg_in = upn_pkg::SEG_TWO;
                  end else begin
                     lst[0] = upn_pkg::CH_SLASH;
                     lst[1] = upn_pkg::CH_DOT;
                     lst[2] = chr;
                     app_k  = 3'd3;
                     seg_in = upn_pkg::SEG_BODY;
                  end
               end
               upn_pkg::SEG_TWO: begin
                  lst[0] = upn_pkg::CH_SLASH;
                  lst[1] = upn_pkg::CH_DOT;
                  lst[2] = upn_pkg::CH_DOT;
                  lst[3] = chr;
                  app_k  = 3'd4;
                  seg_in = upn_pkg::SEG_BODY;
               end
               default: begin
                  lst[0] = chr;
                  app_k  = 3'd1;
               end
            endcase
         end
         // Output length limit: emit what fits, then raise the fault.
         room = LastCnt - base;
         if (room < CntW'(app_k)) begin
            emit    = room[upn_pkg::RES_CNT_W-1:0];
            jflt_in = upn_pkg::FAULT_LONG;
         end else begin
            emit = app_k;
         end
         ocnt_in = base + CntW'(emit);
      end

      nb = emit;

      // End of the request: settle the status and clear the state.
      if (in_last_ff) begin
         dfin = dflt_in;
         if (dfin == upn_pkg::FAULT_NONE && esc_in != upn_pkg::ESC_IDLE) begin
            dfin = upn_pkg::FAULT_INVALID;
         end
         if (dfin != upn_pkg::FAULT_NONE) begin
            st = dfin;
         end else begin
            jfin = jflt_in;
            if (jfin == upn_pkg::FAULT_NONE && dcnt_in == '0) begin
               jfin = upn_pkg::FAULT_INVALID;
            end
            if (jfin == upn_pkg::FAULT_NONE && seg_in == upn_pkg::SEG_TWO) begin
               jfin = upn_pkg::FAULT_INVALID;
            end
            if (jfin != upn_pkg::FAULT_NONE) begin
               st = jfin;
            end else if (pslash_in) begin
               st = upn_pkg::FAULT_LONG;
            end else if (root_ff == '0 && ocnt_in == '0) begin
               // Nothing below the root: the path is the root itself.
               lst[0] = upn_pkg::CH_SLASH;
               nb     = 3'd1;
            end
         end
         esc_in    = upn_pkg::ESC_IDLE;
         hi_in     = '0;
         qry_in    = 1'b0;
         dcnt_in   = '0;
         ocnt_in   = '0;
         seg_in    = upn_pkg::SEG_NONE;
         dflt_in   = upn_pkg::FAULT_NONE;
         jflt_in   = upn_pkg::FAULT_NONE;
         pslash_in = 1'b0;
      end
   end

   // Result beats of this input beat, bytes first and the status last.
   always_comb begin
      bundle.load = proc;
      bundle.cnt  = nb + upn_pkg::RES_CNT_W'(in_last_ff);
      for (int i = 0; i < upn_pkg::MAX_RES; i++) begin
         bundle.ent[i] = '0;
         if (upn_pkg::RES_CNT_W'(i) < nb) begin
            bundle.ent[i].data = lst[i];
            bundle.ent[i].vld  = 1'b1;
         end else if (upn_pkg::RES_CNT_W'(i) == nb && in_last_ff) begin
            bundle.ent[i].eop    = 1'b1;
            bundle.ent[i].status = st;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff    <= upn_pkg::ESC_IDLE;
         hi_ff     <= '0;
         qry_ff    <= 1'b0;
         dcnt_ff   <= '0;
         ocnt_ff   <= '0;
         seg_ff    <= upn_pkg::SEG_NONE;
         dflt_ff   <= upn_pkg::FAULT_NONE;
         jflt_ff   <= upn_pkg::FAULT_NONE;
         pslash_ff <= 1'b0;
      end else if (proc) begin
         esc_ff    <= esc_in;
         hi_ff     <= hi_in;
         qry_ff    <= qry_in;
         dcnt_ff   <= dcnt_in;
         ocnt_ff   <= ocnt_in;
         seg_ff    <= seg_in;
         dflt_ff   <= dflt_in;
         jflt_ff   <= jflt_in;
         pslash_ff <= pslash_in;
      end
   end

endmodule

### rtl/upn_obuf.sv
module upn_obuf (
   input  logic                                clock,
   input  logic                                reset,
   input  upn_pkg::bundle_type                 bundle,
   output logic                                buf_free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [upn_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   logic [upn_pkg::RES_CNT_W-1:0] cnt_ff, cnt_in;
   upn_pkg::entry_type            ent_ff [upn_pkg::MAX_RES];
   logic                          pop;

   assign rsp_tvalid = (cnt_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   // Free when empty or when the last waiting beat leaves in this cycle.
   assign buf_free   = (cnt_ff == '0) || (cnt_ff == 3'd1 && rsp_tready);

   always_comb begin
      cnt_in = cnt_ff;
      if (bundle.load) begin
         cnt_in = bundle.cnt;
      end else if (pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Beats shift toward the head as they are taken.
   always_ff @(posedge clock) begin
      if (bundle.load) begin
         for (int i = 0; i < upn_pkg::MAX_RES; i++) begin
            ent_ff[i] <= bundle.ent[i];
         end
      end else if (pop) begin
         for (int i = 0; i < upn_pkg::MAX_RES - 1; i++) begin
            ent_ff[i] <= ent_ff[i+1];
         end
      end
   end

   assign rsp_tdata = {{(upn_pkg::RSP_DATA_W - upn_pkg::BYTE_W - 2){1'b0}},
                       ent_ff[0].status, ent_ff[0].data};
   assign rsp_tuser = ent_ff[0].vld;
   assign rsp_tlast = ent_ff[0].eop;

endmodule

### rtl/upn_checker.sv
`include "url_path_decode_normalize_macros.svh"

module upn_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic [upn_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input logic                                rsp_tuser,
   input logic                                rsp_tlast
);

   // A status beat carries no path byte and a defined status code.
   `UPN_ASSERT_NOW(a_final_clean, rsp_tvalid && rsp_tlast,
      !rsp_tuser && rsp_tdata[7:0] == 8'h00 && rsp_tdata[9:8] != 2'd3,
      "status beat carries a byte or a bad status")

   // A byte beat never closes the request and carries a zero status.
   `UPN_ASSERT_NOW(a_byte_clean, rsp_tvalid && rsp_tuser,
      !rsp_tlast && rsp_tdata[9:8] == 2'd0,
      "byte beat carries status or end of path")

   // Out of reset the block is empty and ready for a beat.
   `UPN_ASSERT_NEXT(a_reset_empty, reset, !rsp_tvalid && req_tready,
      "block not empty after reset")

endmodule

bind url_path_decode_normalize upn_checker u_chk (.*);
